// ----- hw/rtl/tcf_pkg.sv -----
// Shared types, constants and helper functions of the tilt complementary filter.
package tcf_pkg;

    // Field and register widths
    localparam int SMP_W      = 8;
    localparam int ANG_W      = 25;
    localparam int GAIN_W     = 16;
    localparam int COEF_W     = 17;
    localparam int MAG_W      = 9;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 17;

    // CORDIC sizing: at most 24 iterations are ever run
    localparam int CORDIC_STEPS = 16;
    localparam int CORDIC_RUNS  = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;
    localparam int ITER_W       = (CORDIC_RUNS > 1) ? $clog2(CORDIC_RUNS) : 1;
    localparam int TAB_IDX_W    = 5;
    localparam int CORD_FRAC    = 20;
    localparam int CORD_W       = SMP_W + CORD_FRAC + 3;

    // Shared multiplier and blend accumulator widths
    localparam int MUL_A_W    = ANG_W;
    localparam int MUL_B_W    = COEF_W + 1;
    localparam int PROD_W     = MUL_A_W + MUL_B_W;
    localparam int SUM_W      = PROD_W + 1;
    localparam int BLEND_FRAC = 16;

    localparam logic [COEF_W-1:0]          COEF_ONE     = 17'd65536;
    localparam logic signed [ANG_W-1:0]    QUARTER_TURN = 25'sd5898240;
    localparam logic signed [SUM_W-1:0]    ROUND_HALF   = 44'sd32768;
    localparam logic signed [SUM_W-1:0]    SAT_HI       = 44'sd16777215;
    localparam logic signed [SUM_W-1:0]    SAT_LO       = -44'sd16777216;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GYRO_GAIN  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLEND_COEF = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAG_LOW    = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAG_HIGH   = 4'd3;

    // Configuration reset values
    localparam logic [GAIN_W-1:0] GAIN_RESET     = 16'd37;
    localparam logic [COEF_W-1:0] COEF_RESET     = 17'd1311;
    localparam logic [MAG_W-1:0]  MAG_LOW_RESET  = 9'd32;
    localparam logic [MAG_W-1:0]  MAG_HIGH_RESET = 9'd128;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_X,
        ST_INT_P,
        ST_INT_R,
        ST_CORD_INIT,
        ST_CORD_RUN,
        ST_BLEND_A,
        ST_BLEND_B,
        ST_BLEND_C,
        ST_DONE
    } tcf_state_t;

    typedef enum logic [1:0] {
        MUL_RATE_X,
        MUL_RATE_Y,
        MUL_KEEP,
        MUL_ATAN
    } mul_sel_t;

    typedef enum logic {
        AXIS_PITCH,
        AXIS_ROLL
    } axis_t;

    // Controller to datapath commands
    typedef struct packed {
        logic              load_in;
        logic              gate;
        logic              mul_en;
        mul_sel_t          mul_sel;
        logic              int_pitch;
        logic              int_roll;
        logic              cord_init;
        logic              cord_step;
        logic [ITER_W-1:0] cord_iter;
        axis_t             axis;
        logic              sum_load;
        logic              blend_store;
        logic              out_load;
    } tcf_cmd_t;

    // atan(2^-i) in degrees, Q8.16
    function automatic logic signed [ANG_W-1:0] atan_entry(input logic [TAB_IDX_W-1:0] i);
        logic signed [ANG_W-1:0] r;
        unique case (i)
            5'd0:    r = 25'sd2949120;
            5'd1:    r = 25'sd1740967;
            5'd2:    r = 25'sd919879;
            5'd3:    r = 25'sd466945;
            5'd4:    r = 25'sd234379;
            5'd5:    r = 25'sd117304;
            5'd6:    r = 25'sd58666;
            5'd7:    r = 25'sd29335;
            5'd8:    r = 25'sd14668;
            5'd9:    r = 25'sd7334;
            5'd10:   r = 25'sd3667;
            5'd11:   r = 25'sd1833;
            5'd12:   r = 25'sd917;
            5'd13:   r = 25'sd458;
            5'd14:   r = 25'sd229;
            5'd15:   r = 25'sd115;
            5'd16:   r = 25'sd57;
            5'd17:   r = 25'sd29;
            5'd18:   r = 25'sd14;
            5'd19:   r = 25'sd7;
            5'd20:   r = 25'sd4;
            5'd21:   r = 25'sd2;
            5'd22:   r = 25'sd1;
            default: r = 25'sd0;
        endcase
        return r;
    endfunction

    // Clamp a wide signed value to the Q8.16 angle range
    function automatic logic signed [ANG_W-1:0] sat_ang(input logic signed [SUM_W-1:0] v);
        logic signed [ANG_W-1:0] r;
        if (v > SAT_HI)
            r = SAT_HI[ANG_W-1:0];
        else if (v < SAT_LO)
            r = SAT_LO[ANG_W-1:0];
        else
            r = v[ANG_W-1:0];
        return r;
    endfunction

endpackage

// ----- hw/rtl/tcf_cordic.sv -----
// Vectoring CORDIC unit: atan2(y, x) in Q8.16 degrees, one iteration per cycle.
module tcf_cordic
    import tcf_pkg::*;
(
    input  logic                    clk,
    input  logic                    init,
    input  logic                    step,
    input  logic [ITER_W-1:0]       iter,
    input  logic signed [SMP_W-1:0] y_in,
    input  logic signed [SMP_W-1:0] x_in,
    output logic signed [ANG_W-1:0] angle
);

    logic signed [CORD_W-1:0] cx_reg, cx_next;
    logic signed [CORD_W-1:0] cy_reg, cy_next;
    logic signed [ANG_W-1:0]  z_reg, z_next;
    logic                     zero_reg, zero_next;

    logic signed [CORD_W-1:0] x_s, y_s, sx, sy;
    logic signed [ANG_W-1:0]  rot;

    assign x_s = CORD_W'(x_in) <<< CORD_FRAC;
    assign y_s = CORD_W'(y_in) <<< CORD_FRAC;
    assign sx  = cx_reg >>> iter;
    assign sy  = cy_reg >>> iter;
    assign rot = atan_entry(TAB_IDX_W'(iter));

    // Quadrant pre-rotation on load, micro-rotation on each step
    always_comb
    begin
        cx_next   = cx_reg;
        cy_next   = cy_reg;
        z_next    = z_reg;
        zero_next = zero_reg;
        if (init)
        begin
            zero_next = (x_in == '0) && (y_in == '0);
            if (x_in[SMP_W-1])
            begin
                if (!y_in[SMP_W-1])
                begin
                    cx_next = y_s;
                    cy_next = -x_s;
                    z_next  = QUARTER_TURN;
                end
                else
                begin
                    cx_next = -y_s;
                    cy_next = x_s;
                    z_next  = -QUARTER_TURN;
                end
            end
            else
            begin
                cx_next = x_s;
                cy_next = y_s;
                z_next  = '0;
            end
        end
        else if (step)
        begin
            if (!cy_reg[CORD_W-1])
            begin
                cx_next = cx_reg + sy;
                cy_next = cy_reg - sx;
                z_next  = z_reg + rot;
            end
            else
            begin
                cx_next = cx_reg - sy;
                cy_next = cy_reg + sx;
                z_next  = z_reg - rot;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cx_reg   <= cx_next;
        cy_reg   <= cy_next;
        z_reg    <= z_next;
        zero_reg <= zero_next;
    end

    // A zero vector has no direction; report 0
    assign angle = zero_reg ? '0 : z_reg;

endmodule

// ----- hw/rtl/tcf_datapath.sv -----
// Datapath: configuration, angle state, shared multiplier, gate, blend and output registers.
module tcf_datapath
    import tcf_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  tcf_cmd_t                  cmd,
    input  logic signed [SMP_W-1:0]   acc_x,
    input  logic signed [SMP_W-1:0]   acc_y,
    input  logic signed [SMP_W-1:0]   acc_z,
    input  logic signed [SMP_W-1:0]   rate_x,
    input  logic signed [SMP_W-1:0]   rate_y,
    input  logic                      cfg_we,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_data,
    output logic                      acc_ok,
    output logic signed [ANG_W-1:0]   pitch_angle,
    output logic signed [ANG_W-1:0]   roll_angle,
    output logic                      acc_used
);

    // Configuration
    logic [GAIN_W-1:0] gain_reg, gain_next;
    logic [COEF_W-1:0] coef_reg, coef_next;
    logic [MAG_W-1:0]  mag_low_reg, mag_low_next;
    logic [MAG_W-1:0]  mag_high_reg, mag_high_next;

    // Angle state
    logic signed [ANG_W-1:0] pitch_reg, pitch_next;
    logic signed [ANG_W-1:0] roll_reg, roll_next;
    logic                    used_reg, used_next;

    // Latched sample
    logic signed [SMP_W-1:0] ax_reg, ax_next;
    logic signed [SMP_W-1:0] ay_reg, ay_next;
    logic signed [SMP_W-1:0] az_reg, az_next;
    logic signed [SMP_W-1:0] gx_reg, gx_next;
    logic signed [SMP_W-1:0] gy_reg, gy_next;

    // Arithmetic pipeline
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic signed [SUM_W-1:0]  sum_reg, sum_next;

    // Result holding register
    logic signed [ANG_W-1:0] out_pitch_reg, out_pitch_next;
    logic signed [ANG_W-1:0] out_roll_reg, out_roll_next;
    logic                    out_used_reg, out_used_next;

    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  mul_p;
    logic [COEF_W-1:0]         coef_eff, coef_keep;
    logic [SMP_W-1:0]          abs_x, abs_y, abs_z;
    logic [MAG_W-1:0]          mag;
    logic signed [SUM_W-1:0]   int_p_sum, int_r_sum, blend_sum;
    logic signed [ANG_W-1:0]   blend_val;
    logic signed [ANG_W-1:0]   atan_val;
    logic signed [SMP_W-1:0]   cord_y;

    // Blend weights, coefficient clamped at one
    assign coef_eff  = (coef_reg > COEF_ONE) ? COEF_ONE : coef_reg;
    assign coef_keep = COEF_ONE - coef_eff;

    // Shared multiplier operand selection
    always_comb
    begin
        unique case (cmd.mul_sel)
            MUL_RATE_X:
            begin
                mul_a = MUL_A_W'(gx_reg);
                mul_b = MUL_B_W'(gain_reg);
            end
            MUL_RATE_Y:
            begin
                mul_a = MUL_A_W'(gy_reg);
                mul_b = MUL_B_W'(gain_reg);
            end
            MUL_KEEP:
            begin
                mul_a = (cmd.axis == AXIS_PITCH) ? pitch_reg : roll_reg;
                mul_b = MUL_B_W'(coef_keep);
            end
            MUL_ATAN:
            begin
                mul_a = atan_val;
                mul_b = MUL_B_W'(coef_eff);
            end
        endcase
    end

    assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

    // Magnitude gate
    assign abs_x = ax_reg[SMP_W-1] ? SMP_W'(-ax_reg) : SMP_W'(ax_reg);
    assign abs_y = ay_reg[SMP_W-1] ? SMP_W'(-ay_reg) : SMP_W'(ay_reg);
    assign abs_z = az_reg[SMP_W-1] ? SMP_W'(-az_reg) : SMP_W'(az_reg);
    assign mag   = MAG_W'(abs_x) + MAG_W'(abs_y) + MAG_W'(abs_z);

    // Gyro integration and rounded blend
    assign int_p_sum = SUM_W'(pitch_reg) + SUM_W'(prod_reg);
    assign int_r_sum = SUM_W'(roll_reg) - SUM_W'(prod_reg);
    assign blend_sum = (sum_reg + SUM_W'(prod_reg)) >>> BLEND_FRAC;
    assign blend_val = sat_ang(blend_sum);

    assign cord_y = (cmd.axis == AXIS_PITCH) ? ay_reg : ax_reg;

    tcf_cordic u_cordic (
        .clk   (clk),
        .init  (cmd.cord_init),
        .step  (cmd.cord_step),
        .iter  (cmd.cord_iter),
        .y_in  (cord_y),
        .x_in  (az_reg),
        .angle (atan_val)
    );

    // Configuration writes
    always_comb
    begin
        gain_next     = gain_reg;
        coef_next     = coef_reg;
        mag_low_next  = mag_low_reg;
        mag_high_next = mag_high_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_GYRO_GAIN:  gain_next     = cfg_data[GAIN_W-1:0];
                CFG_BLEND_COEF: coef_next     = cfg_data[COEF_W-1:0];
                CFG_MAG_LOW:    mag_low_next  = cfg_data[MAG_W-1:0];
                CFG_MAG_HIGH:   mag_high_next = cfg_data[MAG_W-1:0];
                default:        ;
            endcase
        end
    end

    // Angle state, gate flag and arithmetic registers
    always_comb
    begin
        pitch_next     = pitch_reg;
        roll_next      = roll_reg;
        used_next      = used_reg;
        ax_next        = ax_reg;
        ay_next        = ay_reg;
        az_next        = az_reg;
        gx_next        = gx_reg;
        gy_next        = gy_reg;
        prod_next      = prod_reg;
        sum_next       = sum_reg;
        out_pitch_next = out_pitch_reg;
        out_roll_next  = out_roll_reg;
        out_used_next  = out_used_reg;

        if (cmd.load_in)
        begin
            ax_next = acc_x;
            ay_next = acc_y;
            az_next = acc_z;
            gx_next = rate_x;
            gy_next = rate_y;
        end
        if (cmd.gate)
            used_next = (mag > mag_low_reg) && (mag < mag_high_reg);
        if (cmd.mul_en)
            prod_next = mul_p;
        if (cmd.sum_load)
            sum_next = SUM_W'(prod_reg) + ROUND_HALF;
        if (cmd.int_pitch)
            pitch_next = sat_ang(int_p_sum);
        if (cmd.int_roll)
            roll_next = sat_ang(int_r_sum);
        if (cmd.blend_store)
        begin
            if (cmd.axis == AXIS_PITCH)
                pitch_next = blend_val;
            else
                roll_next = blend_val;
        end
        if (cmd.out_load)
        begin
            out_pitch_next = pitch_reg;
            out_roll_next  = roll_reg;
            out_used_next  = used_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg     <= GAIN_RESET;
            coef_reg     <= COEF_RESET;
            mag_low_reg  <= MAG_LOW_RESET;
            mag_high_reg <= MAG_HIGH_RESET;
            pitch_reg    <= '0;
            roll_reg     <= '0;
            used_reg     <= 1'b0;
        end
        else
        begin
            gain_reg     <= gain_next;
            coef_reg     <= coef_next;
            mag_low_reg  <= mag_low_next;
            mag_high_reg <= mag_high_next;
            pitch_reg    <= pitch_next;
            roll_reg     <= roll_next;
            used_reg     <= used_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ax_reg        <= ax_next;
        ay_reg        <= ay_next;
        az_reg        <= az_next;
        gx_reg        <= gx_next;
        gy_reg        <= gy_next;
        prod_reg      <= prod_next;
        sum_reg       <= sum_next;
        out_pitch_reg <= out_pitch_next;
        out_roll_reg  <= out_roll_next;
        out_used_reg  <= out_used_next;
    end

    assign acc_ok      = used_reg;
    assign pitch_angle = out_pitch_reg;
    assign roll_angle  = out_roll_reg;
    assign acc_used    = out_used_reg;

endmodule

// ----- hw/rtl/tcf_ctrl.sv -----
// Controller: sequences integration, gate, CORDIC runs and blends; owns the handshakes.
module tcf_ctrl
    import tcf_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    output logic     out_valid,
    input  logic     out_stall,
    input  logic     acc_ok,
    output tcf_cmd_t cmd
);

    localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(CORDIC_RUNS - 1);

    tcf_state_t        state_reg, state_next;
    logic [ITER_W-1:0] iter_reg, iter_next;
    axis_t             axis_reg, axis_next;
    logic              out_valid_reg, out_valid_next;
    logic              out_free;

    // Output register can take a result when empty or being drained
    assign out_free = !out_valid_reg || !out_stall;

    // Next state, iteration counter and axis
    always_comb
    begin
        state_next = state_reg;
        iter_next  = iter_reg;
        axis_next  = axis_reg;
        unique case (state_reg)
            ST_IDLE:
                if (in_valid)
                    state_next = ST_MUL_X;
            ST_MUL_X:
                state_next = ST_INT_P;
            ST_INT_P:
                state_next = ST_INT_R;
            ST_INT_R:
            begin
                axis_next  = AXIS_PITCH;
                state_next = acc_ok ? ST_CORD_INIT : ST_DONE;
            end
            ST_CORD_INIT:
            begin
                iter_next  = '0;
                state_next = ST_CORD_RUN;
            end
            ST_CORD_RUN:
            begin
                iter_next = iter_reg + ITER_W'(1);
                if (iter_reg == ITER_LAST)
                    state_next = ST_BLEND_A;
            end
            ST_BLEND_A:
                state_next = ST_BLEND_B;
            ST_BLEND_B:
                state_next = ST_BLEND_C;
            ST_BLEND_C:
            begin
                if (axis_reg == AXIS_PITCH)
                begin
                    axis_next  = AXIS_ROLL;
                    state_next = ST_CORD_INIT;
                end
                else
                    state_next = ST_DONE;
            end
            ST_DONE:
                if (out_free)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Commands per state
    always_comb
    begin
        cmd           = '0;
        cmd.mul_sel   = MUL_RATE_X;
        cmd.axis      = axis_reg;
        cmd.cord_iter = iter_reg;
        in_stall      = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall    = 1'b0;
                cmd.load_in = in_valid;
            end
            ST_MUL_X:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_RATE_X;
                cmd.gate    = 1'b1;
            end
            ST_INT_P:
            begin
                cmd.int_pitch = 1'b1;
                cmd.mul_en    = 1'b1;
                cmd.mul_sel   = MUL_RATE_Y;
            end
            ST_INT_R:
                cmd.int_roll = 1'b1;
            ST_CORD_INIT:
                cmd.cord_init = 1'b1;
            ST_CORD_RUN:
                cmd.cord_step = 1'b1;
            ST_BLEND_A:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_KEEP;
            end
            ST_BLEND_B:
            begin
                cmd.mul_en   = 1'b1;
                cmd.mul_sel  = MUL_ATAN;
                cmd.sum_load = 1'b1;
            end
            ST_BLEND_C:
                cmd.blend_store = 1'b1;
            ST_DONE:
                cmd.out_load = out_free;
            default:
                ;
        endcase
    end

    // Result valid: set on load, cleared when the transaction completes
    assign out_valid_next = cmd.out_load || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            iter_reg      <= '0;
            axis_reg      <= AXIS_PITCH;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            iter_reg      <= iter_next;
            axis_reg      <= axis_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    // An accepted transaction always starts the integration sequence
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == ST_MUL_X))
        else $error("accepted transaction did not start integration");

    // A result is never loaded over one still waiting to be taken
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !(out_valid_reg && out_stall))
        else $error("result register overwritten while stalled");

    // Loading a result raises valid on the next cycle
    a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> out_valid_reg)
        else $error("loaded result not presented");

    // Every CORDIC run starts at iteration zero
    a_cordic_start: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CORD_INIT) |=> (state_reg == ST_CORD_RUN && iter_reg == '0))
        else $error("CORDIC run did not start at iteration zero");

    // Roll blend only follows a pitch blend within the same item
    a_blend_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_BLEND_C && axis_reg == AXIS_PITCH) |=>
        (state_reg == ST_CORD_INIT && axis_reg == AXIS_ROLL))
        else $error("roll CORDIC run did not follow pitch blend");

endmodule

// ----- hw/rtl/tilt_complementary_filter.sv -----
// Top level of the tilt complementary filter: pitch/roll from one IMU sample per transaction.
//
//   channel   direction  handshake              payload
//   in        input      in_valid / in_stall    acc_x, acc_y, acc_z, rate_x, rate_y
//   out       output     out_valid / out_stall  pitch_angle, roll_angle, acc_used
//   cfg       input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One sample at a time: the next sample is accepted only after the current one has
// loaded its result; when the magnitude gate fails, both CORDIC runs and blends are skipped.
// The single iterative CORDIC unit runs one micro-rotation per cycle for each angle in turn.
// Reset (rst_n, asynchronous) zeroes both angles and loads the register defaults.
// A held result waits in the output register; the next sample is taken meanwhile
// and its result waits for that register to drain. cfg_ready is always high.
module tilt_complementary_filter
    import tcf_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic signed [SMP_W-1:0] acc_x,
    input  logic signed [SMP_W-1:0] acc_y,
    input  logic signed [SMP_W-1:0] acc_z,
    input  logic signed [SMP_W-1:0] rate_x,
    input  logic signed [SMP_W-1:0] rate_y,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic signed [ANG_W-1:0] pitch_angle,
    output logic signed [ANG_W-1:0] roll_angle,
    output logic                    acc_used,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data
);

    tcf_cmd_t cmd;
    logic     acc_ok;

    assign cfg_ready = 1'b1;

    tcf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .acc_ok    (acc_ok),
        .cmd       (cmd)
    );

    tcf_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .acc_x       (acc_x),
        .acc_y       (acc_y),
        .acc_z       (acc_z),
        .rate_x      (rate_x),
        .rate_y      (rate_y),
        .cfg_we      (cfg_valid && cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .acc_ok      (acc_ok),
        .pitch_angle (pitch_angle),
        .roll_angle  (roll_angle),
        .acc_used    (acc_used)
    );

endmodule
